FILE: rtl/kbs_pkg.sv
// shared types and constants for the k-nomial barrier schedule generator
package kbs_pkg;

	localparam int RANK_W    = 10;
	localparam int SIZE_W    = 11;
	localparam int RADIX_W   = 5;
	localparam int STEP_W    = 4;
	localparam int KIND_W    = 3;
	localparam int MAX_RANKS = 1024;
	localparam int MAX_RADIX = 16;
	// largest power count: radix 2 over the largest group
	localparam int MAX_PK    = 10;
	localparam int PK_W      = 4;
	// radix powers stay below MAX_RANKS * MAX_RADIX
	localparam int POW_W     = 15;
	localparam int CFG_ADDR_W = 3;

	localparam logic REG_RADIX = 1'b0;
	localparam logic REG_GROUP = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_SR      = 3'd0,
		KIND_RECV    = 3'd1,
		KIND_SEND    = 3'd2,
		KIND_EMPTY   = 3'd3,
		KIND_INVALID = 3'd4
	} kind_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_index;
		kind_t             kind;
		logic [RANK_W-1:0] peer;
		logic              last_of_step;
		logic              last;
	} entry_t;

endpackage

FILE: rtl/kbs_out_stage.sv
// output register that holds one schedule entry until the receiver takes it
module kbs_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kbs_pkg::entry_t push_entry,
	output logic            can_push,
	output logic            valid,
	input  logic            ready,
	output kbs_pkg::entry_t entry
);
	import kbs_pkg::*;

	logic   valid_q;
	entry_t entry_q;

	// free when empty or emptied in this cycle
	assign can_push = !valid_q || ready;
	assign valid    = valid_q;
	assign entry    = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q <= push_entry;
		end
	end

endmodule

FILE: rtl/knomial_barrier_schedule.sv
// top level of the k-nomial barrier schedule generator
// usage: program the radix (byte address 0) and the group size (byte address 4)
//   over the apb port while the block is idle; reads return the registers
// a rank transaction on req_valid/req_ready/rank starts one schedule; the
//   schedule leaves on sched_valid/sched_ready, one peer entry per transaction,
//   with last on its final entry
// handshake: one rank at a time; req_ready is high only while the sequencer is idle,
//   and it returns to idle as it hands the final entry to the output register
// the sequencer steps through the power search, the full-size sum, the digit
//   split of the rank and the peer walk; a proxy adds a receive step before and
//   a send step after the walk, an extra rank stops after the full-size sum and
//   an invalid rank stops at the range check
// stall: a full output register that is not taken holds the sequencer in place;
//   no entry is dropped or repeated
// reset: radix returns to 2, the group size to 1, the sequencer to idle, and the
//   output register empties
module knomial_barrier_schedule (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [kbs_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// rank request
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [kbs_pkg::RANK_W-1:0]       rank,
	// schedule entries
	output logic                             sched_valid,
	input  logic                             sched_ready,
	output logic [kbs_pkg::STEP_W-1:0]       step_index,
	output logic [kbs_pkg::KIND_W-1:0]       kind,
	output logic [kbs_pkg::RANK_W-1:0]       peer,
	output logic                             last_of_step,
	output logic                             last
);
	import kbs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_POW,
		S_FULL,
		S_DESC,
		S_EXTRA,
		S_RECV,
		S_ISTART,
		S_IPEER,
		S_SEND
	} state_t;

	// configuration registers
	logic [RADIX_W-1:0] radix_q;
	logic [SIZE_W-1:0]  group_q;

	// sequencer state
	state_t             state_q;
	logic [RANK_W-1:0]  rank_q;
	logic [SIZE_W-1:0]  size_q;
	logic [RADIX_W-1:0] r_q;
	logic [POW_W-1:0]   fs_q;
	logic [SIZE_W-1:0]  prev_q;
	logic [PK_W-1:0]    pk_q;
	logic [SIZE_W-1:0]  ft_q;
	logic [SIZE_W-1:0]  acc_q;
	logic [SIZE_W-1:0]  full_q;
	logic               proxy_q;
	logic [RANK_W-1:0]  cur_q;
	logic [PK_W-1:0]    lvl_q;
	logic [PK_W-1:0]    it_q;
	logic [POW_W-1:0]   rpow_q;
	logic [POW_W-1:0]   span_q;
	logic [POW_W-1:0]   w_q;
	logic [RANK_W-1:0]  base_q;
	logic [RADIX_W-1:0] k_q;
	logic               pend_v_q;
	logic [RANK_W-1:0]  pend_peer_q;
	logic [STEP_W-1:0]  step_q;

	// radix powers r^0..r^p and rank mod r^(i+1) for each iteration
	logic [POW_W-1:0]   pw_q  [0:MAX_PK];
	logic [RANK_W-1:0]  off_q [0:MAX_PK-1];

	// combinational datapath
	logic [SIZE_W-1:0]  size_eff;
	logic [RADIX_W-1:0] r_lo;
	logic [RADIX_W-1:0] r_eff;
	logic [POW_W-1:0]   prod;
	logic               pow_more;
	logic [SIZE_W:0]    acc_sum;
	logic               acc_fits;
	logic               is_extra;
	logic               invalid;
	logic [POW_W-1:0]   pw_lvl;
	logic               desc_ge;
	logic [PK_W-1:0]    it_nx;
	logic [POW_W:0]     nw_raw;
	logic [POW_W-1:0]   nw;
	logic [POW_W:0]     peer_full;
	logic               peer_ok;
	logic               last_it;
	logic               k_run;

	logic               push_req;
	entry_t             push_ent;
	logic               go;
	logic               can_push;
	entry_t             out_ent;

	// apb configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_W'(2);
			group_q <= SIZE_W'(1);
		end else if (psel && penable && pwrite) begin
			case (paddr[CFG_ADDR_W-1])
				REG_RADIX: radix_q <= pwdata[RADIX_W-1:0];
				REG_GROUP: group_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[CFG_ADDR_W-1])
			REG_RADIX: prdata = {{(32-RADIX_W){1'b0}}, radix_q};
			REG_GROUP: prdata = {{(32-SIZE_W){1'b0}}, group_q};
			default:   prdata = '0;
		endcase
	end

	// clamp group size, then radix into [2, MAX_RADIX] and to the group size
	assign size_eff = (group_q > SIZE_W'(MAX_RANKS)) ? SIZE_W'(MAX_RANKS) : group_q;
	assign r_lo     = (radix_q < RADIX_W'(2))         ? RADIX_W'(2) :
	                  (radix_q > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_q;
	assign r_eff    = ({{(SIZE_W-RADIX_W){1'b0}}, r_lo} > size_eff) ?
	                  size_eff[RADIX_W-1:0] : r_lo;

	assign invalid  = {1'b0, rank_q} >= size_q;

	// power search: one multiply per cycle
	assign prod     = POW_W'(fs_q * {{(POW_W-RADIX_W){1'b0}}, r_q});
	assign pow_more = (r_q >= RADIX_W'(2)) && (fs_q < {{(POW_W-SIZE_W){1'b0}}, size_q});

	// full size: add one full subtree per cycle while it still fits
	assign acc_sum  = {1'b0, acc_q} + {1'b0, ft_q};
	assign acc_fits = acc_sum <= {1'b0, size_q};
	assign is_extra = {1'b0, rank_q} >= acc_q;

	// digit split from the top level down
	assign pw_lvl   = pw_q[lvl_q];
	assign desc_ge  = {{(POW_W-RANK_W){1'b0}}, cur_q} >= pw_lvl;

	// peer walk: next residue mod span, offset by the subtree base
	assign it_nx     = it_q + PK_W'(1);
	assign nw_raw    = {1'b0, w_q} + {1'b0, rpow_q};
	assign nw        = (nw_raw >= {1'b0, span_q}) ? POW_W'(nw_raw - {1'b0, span_q}) :
	                   nw_raw[POW_W-1:0];
	assign peer_full = {{(POW_W+1-RANK_W){1'b0}}, base_q} + {1'b0, nw};
	assign peer_ok   = peer_full < {{(POW_W+1-SIZE_W){1'b0}}, full_q};
	assign last_it   = it_q == PK_W'(pk_q - PK_W'(1));
	assign k_run     = k_q < r_q;

	// entry to hand to the output register in this state
	always_comb begin
		push_req = 1'b0;
		push_ent = '{step_index: step_q, kind: KIND_SR, peer: '0,
		             last_of_step: 1'b0, last: 1'b0};
		case (state_q)
			S_CHECK: begin
				if (invalid) begin
					push_req = 1'b1;
					push_ent = '{step_index: '0, kind: KIND_INVALID, peer: '0,
					             last_of_step: 1'b1, last: 1'b1};
				end
			end
			S_EXTRA: begin
				push_req = 1'b1;
				push_ent = '{step_index: '0, kind: KIND_SR,
				             peer: RANK_W'(rank_q - full_q[RANK_W-1:0]),
				             last_of_step: 1'b1, last: 1'b1};
			end
			S_RECV: begin
				push_req = 1'b1;
				push_ent = '{step_index: step_q, kind: KIND_RECV,
				             peer: RANK_W'({1'b0, rank_q} + full_q),
				             last_of_step: 1'b1, last: 1'b0};
			end
			S_SEND: begin
				push_req = 1'b1;
				push_ent = '{step_index: step_q, kind: KIND_SEND,
				             peer: RANK_W'({1'b0, rank_q} + full_q),
				             last_of_step: 1'b1, last: 1'b1};
			end
			S_IPEER: begin
				if (k_run) begin
					// a new peer releases the one held back
					if (peer_ok && pend_v_q) begin
						push_req = 1'b1;
						push_ent = '{step_index: step_q, kind: KIND_SR, peer: pend_peer_q,
						             last_of_step: 1'b0, last: 1'b0};
					end
				end else begin
					// close the step with the held peer or an empty entry
					push_req = 1'b1;
					push_ent = '{step_index: step_q,
					             kind: pend_v_q ? KIND_SR : KIND_EMPTY,
					             peer: pend_v_q ? pend_peer_q : '0,
					             last_of_step: 1'b1,
					             last: last_it && !proxy_q};
				end
			end
			default: ;
		endcase
	end

	assign go        = !push_req || can_push;
	assign req_ready = state_q == S_IDLE;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rank_q      <= '0;
			size_q      <= '0;
			r_q         <= '0;
			fs_q        <= '0;
			prev_q      <= '0;
			pk_q        <= '0;
			ft_q        <= '0;
			acc_q       <= '0;
			full_q      <= '0;
			proxy_q     <= 1'b0;
			cur_q       <= '0;
			lvl_q       <= '0;
			it_q        <= '0;
			rpow_q      <= '0;
			span_q      <= '0;
			w_q         <= '0;
			base_q      <= '0;
			k_q         <= '0;
			pend_v_q    <= 1'b0;
			pend_peer_q <= '0;
			step_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						rank_q  <= rank;
						size_q  <= size_eff;
						r_q     <= r_eff;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (invalid) begin
						if (go) begin
							state_q <= S_IDLE;
						end
					end else begin
						fs_q    <= {{(POW_W-RADIX_W){1'b0}}, r_q};
						prev_q  <= SIZE_W'(1);
						pk_q    <= PK_W'(1);
						state_q <= S_POW;
					end
				end
				S_POW: begin
					if (pow_more) begin
						fs_q   <= prod;
						prev_q <= fs_q[SIZE_W-1:0];
						pk_q   <= pk_q + PK_W'(1);
					end else begin
						// full subtree is r^p on an exact fit, else r^(p-1)
						ft_q    <= (fs_q != {{(POW_W-SIZE_W){1'b0}}, size_q}) ? prev_q : size_q;
						acc_q   <= '0;
						state_q <= S_FULL;
					end
				end
				S_FULL: begin
					if (acc_fits) begin
						acc_q <= acc_sum[SIZE_W-1:0];
					end else begin
						full_q <= acc_q;
						if (is_extra) begin
							state_q <= S_EXTRA;
						end else begin
							proxy_q <= (size_q > acc_q) && ({1'b0, rank_q} < (size_q - acc_q));
							cur_q   <= rank_q;
							lvl_q   <= PK_W'(pk_q - PK_W'(1));
							state_q <= S_DESC;
						end
					end
				end
				S_DESC: begin
					if (lvl_q == '0) begin
						it_q     <= '0;
						rpow_q   <= POW_W'(1);
						step_q   <= '0;
						pend_v_q <= 1'b0;
						state_q  <= proxy_q ? S_RECV : S_ISTART;
					end else if (desc_ge) begin
						cur_q <= RANK_W'(cur_q - pw_lvl[RANK_W-1:0]);
					end else begin
						lvl_q <= PK_W'(lvl_q - PK_W'(1));
					end
				end
				S_EXTRA: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				S_RECV: begin
					if (go) begin
						step_q  <= step_q + STEP_W'(1);
						state_q <= S_ISTART;
					end
				end
				S_ISTART: begin
					span_q  <= pw_q[it_nx];
					w_q     <= {{(POW_W-RANK_W){1'b0}}, off_q[it_q]};
					base_q  <= RANK_W'(rank_q - off_q[it_q]);
					k_q     <= RADIX_W'(1);
					state_q <= S_IPEER;
				end
				S_IPEER: begin
					if (go) begin
						if (k_run) begin
							w_q <= nw;
							k_q <= k_q + RADIX_W'(1);
							if (peer_ok) begin
								pend_v_q    <= 1'b1;
								pend_peer_q <= peer_full[RANK_W-1:0];
							end
						end else begin
							pend_v_q <= 1'b0;
							step_q   <= step_q + STEP_W'(1);
							rpow_q   <= span_q;
							it_q     <= it_nx;
							if (last_it) begin
								state_q <= proxy_q ? S_SEND : S_IDLE;
							end else begin
								state_q <= S_ISTART;
							end
						end
					end
				end
				S_SEND: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// power and digit tables
	always_ff @(posedge clk) begin
		case (state_q)
			S_CHECK: begin
				if (!invalid) begin
					pw_q[0] <= POW_W'(1);
					pw_q[1] <= {{(POW_W-RADIX_W){1'b0}}, r_q};
				end
			end
			S_POW: begin
				if (pow_more) begin
					pw_q[PK_W'(pk_q + PK_W'(1))] <= prod;
				end
			end
			S_FULL: begin
				if (!acc_fits && !is_extra) begin
					off_q[PK_W'(pk_q - PK_W'(1))] <= rank_q;
				end
			end
			S_DESC: begin
				if ((lvl_q != '0) && !desc_ge) begin
					off_q[PK_W'(lvl_q - PK_W'(1))] <= cur_q;
				end
			end
			default: ;
		endcase
	end

	kbs_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_req && can_push),
		.push_entry (push_ent),
		.can_push   (can_push),
		.valid      (sched_valid),
		.ready      (sched_ready),
		.entry      (out_ent)
	);

	assign step_index   = out_ent.step_index;
	assign kind         = out_ent.kind;
	assign peer         = out_ent.peer;
	assign last_of_step = out_ent.last_of_step;
	assign last         = out_ent.last;

	// a held peer only exists inside a step's peer walk
	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == S_IPEER))
		else $error("held peer outside the peer walk");

	// the final entry is only handed over as the sequencer returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push_req && can_push && push_ent.last) |=> (state_q == S_IDLE))
		else $error("final entry while the sequencer stays busy");

	// digit split stays within the power table
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DESC) |-> (lvl_q < pk_q))
		else $error("digit level beyond power count");

	// iteration counter stays within the power count during the walk
	a_it_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ISTART) || (state_q == S_IPEER)) |-> (it_q < pk_q))
		else $error("iteration beyond power count");

	// an empty step entry always closes its step with no peer
	a_empty_close: assert property (@(posedge clk) disable iff (!arst_n)
		(push_req && (push_ent.kind == KIND_EMPTY)) |->
			(push_ent.last_of_step && (push_ent.peer == '0)))
		else $error("empty entry that does not close its step");

endmodule
